/* rtl/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes for the I2C master byte engine: operation codes,
// tick beat payloads and the classified queue entry.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Operation codes (command field and engine operation register)
  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // Bit that marks the acknowledge slot of a byte (bit count of 8 or more)
  localparam int unsigned ACK_SLOT_BIT = 3;

  // Depth of the queue between classifier and engine
  localparam int unsigned Q_DEPTH = 2;

  // One tick beat into the block
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_sample;
  } tick_in_t;

  // One tick beat out of the block
  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_nack;
  } tick_out_t;

  // Classified tick: command decoded to a legal operation or idle
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_sample;
  } tick_cls_t;

endpackage

/* rtl/i2c_master_byte_engine.sv */
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master bus engine stepped by one tick beat per bus delay period.
//
// Channels: cmd (valid/ready, tick_in_t) carries one tick: a command code,
// the byte to write, the ACK choice for a read and the sampled SDA level.
// res (valid/ready, tick_out_t) returns one beat per tick: SCL level, SDA
// release, busy, done, the last read byte and the last write acknowledge.
// Commands arriving while a command runs are ignored.
// Start and stop take 3 ticks, write and read byte 19 ticks each.
// A tick's beat is written into the classifier queue and, once popped, stepped
// into the engine output register, which holds the result until res takes it.
// Throughput: one tick per cycle while res_ready stays high.
// Reset (rst, synchronous): engine idle, SCL high, SDA released, read byte
// and acknowledge zero, queue and output register empty.
// Stall: when res_ready is low the output register holds its beat, the
// engine stops, and the 2-entry queue fills before cmd_ready drops.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine
  import i2cm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  tick_in_t  cmd,
  output logic      res_valid,
  input  logic      res_ready,
  output tick_out_t res
);

  logic      q_valid;
  logic      q_pop;
  tick_cls_t q_item;

  // Classifier and tick queue
  i2cm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  // Bus engine and output register
  i2cm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

/* rtl/i2cm_front.sv */
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts tick beats, decodes the command code (undefined codes become no
// command) and holds classified ticks in a small queue for the engine.
// ----------------------------------------------------------------------------
module i2cm_front
  import i2cm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  tick_in_t  cmd,
  output logic      q_valid,
  input  logic      q_pop,
  output tick_cls_t q_item
);

  localparam int unsigned PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(Q_DEPTH + 1);

  tick_cls_t         entries [Q_DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  tick_cls_t         cls;
  logic              push;

  // Classify the incoming beat
  always_comb begin
    cls            = '0;
    cls.write_data = cmd.write_data;
    cls.send_ack   = cmd.send_ack;
    cls.sda_sample = cmd.sda_sample;
    if (cmd.command == OP_START || cmd.command == OP_STOP ||
        cmd.command == OP_WRITE || cmd.command == OP_READ) begin
      cls.op = cmd.command;
    end else begin
      cls.op = OP_IDLE;
    end
  end

  assign cmd_ready = (count != CntW'(Q_DEPTH));
  assign push      = cmd_valid && cmd_ready;
  assign q_valid   = (count != '0);
  assign q_item    = entries[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/i2cm_back.sv */
// ----------------------------------------------------------------------------
// i2cm_back
// Bus engine: advances the running command one phase per tick, drives the
// SCL/SDA levels and holds each tick's result in an output register.
// ----------------------------------------------------------------------------
module i2cm_back
  import i2cm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_pop,
  input  tick_cls_t q_item,
  output logic      res_valid,
  input  logic      res_ready,
  output tick_out_t res
);

  // Engine state
  logic [2:0] operation;
  logic [1:0] phase;
  logic [3:0] bit_index;
  logic [7:0] shift_byte;
  logic       ack_choice;
  logic       scl_reg;
  logic       sda_reg;
  logic       ack_reg;
  logic [7:0] last_read;

  logic [2:0] operation_next;
  logic [1:0] phase_next;
  logic [3:0] bit_index_next;
  logic [7:0] shift_byte_next;
  logic       ack_choice_next;
  logic       scl_next;
  logic       sda_next;
  logic       ack_next;
  logic [7:0] last_read_next;
  logic       busy;
  logic       done;

  // Take a tick when the output register is free or being drained
  assign q_pop = q_valid && (!res_valid || res_ready);

  // One tick of the bus sequencer
  always_comb begin
    operation_next  = operation;
    phase_next      = phase;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    ack_choice_next = ack_choice;
    scl_next        = scl_reg;
    sda_next        = sda_reg;
    ack_next        = ack_reg;
    last_read_next  = last_read;
    done            = 1'b0;

    // Launch a new command only when idle
    if (operation == OP_IDLE && q_item.op != OP_IDLE) begin
      operation_next = q_item.op;
      phase_next     = '0;
      bit_index_next = '0;
      if (q_item.op == OP_WRITE) begin
        shift_byte_next = q_item.write_data;
      end
      if (q_item.op == OP_READ) begin
        shift_byte_next = '0;
        ack_choice_next = q_item.send_ack;
      end
    end

    busy = (operation_next != OP_IDLE);

    if (busy) begin
      unique case (operation_next)
        OP_START: begin
          if (phase_next == 2'd0) begin
            scl_next = 1'b1; sda_next = 1'b1; phase_next = 2'd1;
          end else if (phase_next == 2'd1) begin
            scl_next = 1'b1; sda_next = 1'b0; phase_next = 2'd2;
          end else begin
            scl_next = 1'b0; sda_next = 1'b0; done = 1'b1;
          end
        end
        OP_STOP: begin
          if (phase_next == 2'd0) begin
            scl_next = 1'b0; sda_next = 1'b0; phase_next = 2'd1;
          end else if (phase_next == 2'd1) begin
            scl_next = 1'b1; sda_next = 1'b0; phase_next = 2'd2;
          end else begin
            scl_next = 1'b1; sda_next = 1'b1; done = 1'b1;
          end
        end
        OP_WRITE: begin
          if (!bit_index_next[ACK_SLOT_BIT]) begin
            // data bit, MSB first
            sda_next = shift_byte_next[7];
            if (phase_next == 2'd0) begin
              scl_next   = 1'b0;
              phase_next = 2'd1;
            end else begin
              scl_next        = 1'b1;
              shift_byte_next = {shift_byte_next[6:0], 1'b0};
              bit_index_next  = bit_index_next + 4'd1;
              phase_next      = 2'd0;
            end
          end else begin
            // acknowledge slot: release SDA, sample on the high phase
            sda_next = 1'b1;
            if (phase_next == 2'd0) begin
              scl_next   = 1'b0;
              phase_next = 2'd1;
            end else if (phase_next == 2'd1) begin
              scl_next   = 1'b1;
              ack_next   = q_item.sda_sample;
              phase_next = 2'd2;
            end else begin
              scl_next = 1'b0;
              done     = 1'b1;
            end
          end
        end
        default: begin
          // read byte
          if (!bit_index_next[ACK_SLOT_BIT]) begin
            sda_next = 1'b1;
            if (phase_next == 2'd0) begin
              scl_next   = 1'b0;
              phase_next = 2'd1;
            end else begin
              scl_next        = 1'b1;
              shift_byte_next = {shift_byte_next[6:0], q_item.sda_sample};
              bit_index_next  = bit_index_next + 4'd1;
              phase_next      = 2'd0;
            end
          end else begin
            sda_next = !ack_choice_next;
            if (phase_next == 2'd0) begin
              scl_next   = 1'b0;
              phase_next = 2'd1;
            end else if (phase_next == 2'd1) begin
              scl_next   = 1'b1;
              phase_next = 2'd2;
            end else begin
              scl_next       = 1'b0;
              last_read_next = shift_byte_next;
              done           = 1'b1;
            end
          end
        end
      endcase

      if (done) begin
        operation_next = OP_IDLE;
        phase_next     = '0;
        bit_index_next = '0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      operation  <= OP_IDLE;
      phase      <= '0;
      bit_index  <= '0;
      shift_byte <= '0;
      ack_choice <= 1'b0;
      scl_reg    <= 1'b1;
      sda_reg    <= 1'b1;
      ack_reg    <= 1'b0;
      last_read  <= '0;
    end else if (q_pop) begin
      operation  <= operation_next;
      phase      <= phase_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      ack_choice <= ack_choice_next;
      scl_reg    <= scl_next;
      sda_reg    <= sda_next;
      ack_reg    <= ack_next;
      last_read  <= last_read_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_pop) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res.scl_level   <= scl_next;
      res.sda_release <= sda_next;
      res.busy_res    <= busy;
      res.done_res    <= done;
      res.read_byte   <= last_read_next;
      res.ack_nack    <= ack_next;
    end
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C master byte engine. Every tick beat sent on
// the cmd channel is run through a local model of the engine, and each res
// beat is checked field by field against the oldest prediction. A short
// table of directed ticks comes first, then random command streams.
// ----------------------------------------------------------------------------
module tb;
  import i2cm_pkg::*;

  // Command codes above the legal range are taken as no command
  localparam logic [2:0] CMD_UNDEF_LO = OP_READ + 3'd1;
  localparam logic [2:0] CMD_UNDEF_HI = 3'd7;
  localparam int         START_TICKS  = 3;
  localparam int         BYTE_TICKS   = 19;
  localparam int         RAND_TICKS   = 900;
  localparam int         QUIET_TICKS  = 150;
  localparam int         PRINT_LIMIT  = 50;

  typedef struct {
    bit        known;
    tick_out_t value;
  } fixed_out_t;

  typedef struct {
    tick_in_t  beat;
    int        reps;
    bit        known;
    tick_out_t value;
  } tick_row_t;

  logic      clk;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_ready;
  tick_in_t  cmd;
  logic      res_valid;
  logic      res_ready = 1'b1;
  tick_out_t res;

  // Local engine model state
  logic [2:0] eng_op        = OP_IDLE;
  logic [1:0] eng_phase     = '0;
  logic [3:0] eng_bits      = '0;
  logic [7:0] eng_shift     = '0;
  logic       eng_ack_sel   = 1'b0;
  logic       eng_scl       = 1'b1;
  logic       eng_sda       = 1'b1;
  logic       eng_ack_seen  = 1'b0;
  logic [7:0] eng_last_read = '0;

  tick_out_t  expected_ticks[$];
  fixed_out_t fixed_ticks[$];
  tick_row_t  directed_rows[$];

  int started[5];
  int ticks_sent    = 0;
  int beats_checked = 0;
  int fails         = 0;
  int idle_pct      = 0;
  int stall_left    = 0;

  i2c_master_byte_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("%0t: timeout, %0d results still outstanding", $time, expected_ticks.size());
    $display("*** FAILED ***");
    $finish;
  end

  // One bus tick of the engine: picks up a command when idle, then advances
  task automatic step_engine(input tick_in_t t, output tick_out_t r);
    logic busy;
    logic done;
    busy = 1'b0;
    done = 1'b0;
    if (eng_op == OP_IDLE && t.command >= OP_START && t.command <= OP_READ) begin
      eng_op    = t.command;
      eng_phase = '0;
      eng_bits  = '0;
      started[t.command]++;
      if (t.command == OP_WRITE) eng_shift = t.write_data;
      if (t.command == OP_READ) begin
        eng_shift   = '0;
        eng_ack_sel = t.send_ack;
      end
    end
    if (eng_op != OP_IDLE) begin
      busy = 1'b1;
      case (eng_op)
        OP_START: begin
          if (eng_phase == 2'd0) begin
            eng_scl = 1'b1; eng_sda = 1'b1; eng_phase = 2'd1;
          end else if (eng_phase == 2'd1) begin
            eng_scl = 1'b1; eng_sda = 1'b0; eng_phase = 2'd2;
          end else begin
            eng_scl = 1'b0; eng_sda = 1'b0; done = 1'b1;
          end
        end
        OP_STOP: begin
          if (eng_phase == 2'd0) begin
            eng_scl = 1'b0; eng_sda = 1'b0; eng_phase = 2'd1;
          end else if (eng_phase == 2'd1) begin
            eng_scl = 1'b1; eng_sda = 1'b0; eng_phase = 2'd2;
          end else begin
            eng_scl = 1'b1; eng_sda = 1'b1; done = 1'b1;
          end
        end
        OP_WRITE: begin
          // data bits MSB first, then release SDA and sample the acknowledge
          if (eng_bits < 4'd8) begin
            eng_sda = eng_shift[7];
            if (eng_phase == 2'd0) begin
              eng_scl = 1'b0; eng_phase = 2'd1;
            end else begin
              eng_scl   = 1'b1;
              eng_shift = {eng_shift[6:0], 1'b0};
              eng_bits++;
              eng_phase = 2'd0;
            end
          end else begin
            eng_sda = 1'b1;
            if (eng_phase == 2'd0) begin
              eng_scl = 1'b0; eng_phase = 2'd1;
            end else if (eng_phase == 2'd1) begin
              eng_scl = 1'b1; eng_ack_seen = t.sda_sample; eng_phase = 2'd2;
            end else begin
              eng_scl = 1'b0; done = 1'b1;
            end
          end
        end
        default: begin
          // read: sample on high clock, then drive ACK low or leave NACK high
          if (eng_bits < 4'd8) begin
            eng_sda = 1'b1;
            if (eng_phase == 2'd0) begin
              eng_scl = 1'b0; eng_phase = 2'd1;
            end else begin
              eng_scl   = 1'b1;
              eng_shift = {eng_shift[6:0], t.sda_sample};
              eng_bits++;
              eng_phase = 2'd0;
            end
          end else begin
            eng_sda = ~eng_ack_sel;
            if (eng_phase == 2'd0) begin
              eng_scl = 1'b0; eng_phase = 2'd1;
            end else if (eng_phase == 2'd1) begin
              eng_scl = 1'b1; eng_phase = 2'd2;
            end else begin
              eng_scl = 1'b0; eng_last_read = eng_shift; done = 1'b1;
            end
          end
        end
      endcase
      if (done) begin
        eng_op    = OP_IDLE;
        eng_phase = '0;
        eng_bits  = '0;
      end
    end
    r = '{eng_scl, eng_sda, busy, done, eng_last_read, eng_ack_seen};
  endtask

  task automatic compare_beat(input tick_out_t want, input tick_out_t got);
    bit bad;
    bad = 1'b0;
    if (got.scl_level !== want.scl_level) bad = 1'b1;
    if (got.sda_release !== want.sda_release) bad = 1'b1;
    if (got.busy_res !== want.busy_res) bad = 1'b1;
    if (got.done_res !== want.done_res) bad = 1'b1;
    if (got.read_byte !== want.read_byte) bad = 1'b1;
    if (got.ack_nack !== want.ack_nack) bad = 1'b1;
    beats_checked++;
    if (bad) begin
      if (fails < PRINT_LIMIT) begin
        $display("%0t: mismatch expected scl=%b sda=%b busy=%b done=%b rd=%h ack=%b",
                 $time, want.scl_level, want.sda_release, want.busy_res,
                 want.done_res, want.read_byte, want.ack_nack);
        $display("%0t:          actual   scl=%b sda=%b busy=%b done=%b rd=%h ack=%b",
                 $time, got.scl_level, got.sda_release, got.busy_res,
                 got.done_res, got.read_byte, got.ack_nack);
      end
      fails++;
    end
  endtask

  // Predict on every accepted tick, check every accepted result beat
  always @(posedge clk) begin : monitor
    tick_out_t  predicted;
    fixed_out_t fixed;
    if (!rst && cmd_valid && cmd_ready) begin
      step_engine(cmd, predicted);
      ticks_sent++;
      fixed = fixed_ticks.pop_front();
      expected_ticks.push_back(fixed.known ? fixed.value : predicted);
    end
    if (!rst && res_valid && res_ready) begin
      if (expected_ticks.size() == 0) begin
        if (fails < PRINT_LIMIT)
          $display("%0t: result beat with nothing expected, actual %h", $time, res);
        fails++;
      end else begin
        compare_beat(expected_ticks.pop_front(), res);
      end
    end
  end

  // Result side back-pressure in short random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      res_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      res_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      res_ready <= 1'b1;
    end
  end

  // Send one tick beat, with an optional idle burst ahead of it
  task automatic send_tick(input tick_in_t t, input bit known, input tick_out_t value);
    fixed_out_t f;
    f.known = known;
    f.value = value;
    if ($urandom_range(0, 99) < idle_pct) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    fixed_ticks.push_back(f);
    cmd_valid <= 1'b1;
    cmd       <= t;
    do @(posedge clk); while (!cmd_ready);
  endtask

  task automatic add_row(input logic [2:0] command, input logic [7:0] data,
                         input logic sack, input logic sda, input int reps,
                         input bit known, input tick_out_t value);
    tick_row_t row;
    row.beat  = '{command, data, sack, sda};
    row.reps  = reps;
    row.known = known;
    row.value = value;
    directed_rows.push_back(row);
  endtask

  initial begin : stimulus
    tick_in_t t;
    int       ticks_left;
    int       sel;
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    ticks_left = 0;
    foreach (started[i]) started[i] = 0;

    // Directed ticks: idle hold, unknown codes, start with ignored commands,
    // write of all ones with NACK, read with ACK, stop
    add_row(OP_IDLE,      8'h00, 1'b0, 1'b0, 1, 1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0});
    add_row(CMD_UNDEF_HI, 8'hFF, 1'b1, 1'b1, 1, 1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0});
    add_row(CMD_UNDEF_LO, 8'h55, 1'b0, 1'b1, 1, 1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0});
    add_row(OP_IDLE + 3'd6, 8'h80, 1'b1, 1'b0, 1, 1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0});
    add_row(OP_START,     8'h00, 1'b0, 1'b0, 1, 1, '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0});
    add_row(OP_STOP,      8'hFF, 1'b1, 1'b1, 1, 1, '{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0});
    add_row(OP_WRITE,     8'hAA, 1'b0, 1'b0, 1, 1, '{1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0});
    add_row(OP_IDLE,      8'h00, 1'b0, 1'b1, 1, 1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0});
    add_row(OP_WRITE,     8'hFF, 1'b0, 1'b1, 1, 0, '0);
    add_row(OP_READ,      8'h00, 1'b1, 1'b1, BYTE_TICKS - 1, 0, '0);
    add_row(OP_READ,      8'hFF, 1'b1, 1'b1, 1, 0, '0);
    add_row(OP_WRITE,     8'h00, 1'b0, 1'b1, BYTE_TICKS - 1, 0, '0);
    add_row(OP_STOP,      8'h00, 1'b0, 1'b0, 1, 1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'hFF, 1'b1});
    add_row(OP_WRITE,     8'h01, 1'b0, 1'b1, 1, 1, '{1'b1, 1'b0, 1'b1, 1'b0, 8'hFF, 1'b1});
    add_row(OP_READ,      8'h7F, 1'b1, 1'b0, 1, 1, '{1'b1, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b1});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 20;
    foreach (directed_rows[i])
      repeat (directed_rows[i].reps)
        send_tick(directed_rows[i].beat, directed_rows[i].known, directed_rows[i].value);

    // Random command streams; while busy, every field is noise
    for (int n = 0; n < RAND_TICKS; n++) begin
      if (n >= RAND_TICKS - QUIET_TICKS) idle_pct = 0;
      else if (n % 64 == 0) begin
        sel = $urandom_range(0, 2);
        idle_pct = (sel == 0) ? 0 : (sel == 1) ? 12 : 40;
      end
      sel = $urandom_range(0, 7);
      t.write_data = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      t.send_ack   = 1'($urandom_range(0, 1));
      t.sda_sample = 1'($urandom_range(0, 1));
      if (ticks_left == 0) begin
        sel = $urandom_range(0, 99);
        if (sel < 10)      t.command = OP_IDLE;
        else if (sel < 16) t.command = 3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
        else if (sel < 31) t.command = OP_START;
        else if (sel < 45) t.command = OP_STOP;
        else if (sel < 73) t.command = OP_WRITE;
        else               t.command = OP_READ;
        if (t.command == OP_START || t.command == OP_STOP) ticks_left = START_TICKS - 1;
        else if (t.command == OP_WRITE || t.command == OP_READ) ticks_left = BYTE_TICKS - 1;
      end else begin
        t.command = 3'($urandom_range(OP_IDLE, CMD_UNDEF_HI));
        ticks_left--;
      end
      send_tick(t, 1'b0, '0);
    end
    cmd_valid <= 1'b0;

    // Drain, then a few spare cycles
    @(posedge clk);
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d ticks: %0d starts, %0d stops, %0d byte writes, %0d byte reads",
             ticks_sent, started[OP_START], started[OP_STOP], started[OP_WRITE],
             started[OP_READ]);
    $display("Compared %0d result beats, %0d mismatching", beats_checked, fails);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
